@@ rtl/ssw_pkg.sv @@
// Shared types and constants for the slot stopwatch block.
package ssw_pkg;

  localparam int unsigned STAMP_W = 32;
  localparam logic [STAMP_W-1:0] MIN_RESET_VALUE = 32'd1000000000;

  localparam logic [1:0] ACT_BEGIN = 2'd0;
  localparam logic [1:0] ACT_END   = 2'd1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SLOT   = 2'd1,
    ST_BAD_ACTION = 2'd2
  } status_t;

  typedef struct packed {
    logic [STAMP_W-1:0] min_seen;
    logic [STAMP_W-1:0] max_seen;
    logic [STAMP_W-1:0] begin_stamp;
  } slot_rec_t;

  typedef struct packed {
    logic      en;
    slot_rec_t rec;
  } rec_wr_t;

  typedef struct packed {
    status_t            status;
    logic [STAMP_W-1:0] elapsed;
    logic [STAMP_W-1:0] max_elapsed;
    logic [STAMP_W-1:0] min_elapsed;
  } upd_result_t;

endpackage

@@ rtl/ssw_slot_mem.sv @@
// Slot record memory with per-entry valid bits and a registered read port.
module ssw_slot_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output ssw_pkg::slot_rec_t rd_rec,
  input  logic [AW-1:0]     wr_addr,
  input  ssw_pkg::rec_wr_t  wr
);
  import ssw_pkg::*;

  slot_rec_t        mem [DEPTH];
  logic [DEPTH-1:0] valid;
  slot_rec_t        rd_data;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.rec;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  // An entry never written since reset reads as the reset record.
  always_comb begin
    if (rd_valid) begin
      rd_rec = rd_data;
    end else begin
      rd_rec.begin_stamp = '0;
      rd_rec.max_seen    = '0;
      rd_rec.min_seen    = MIN_RESET_VALUE;
    end
  end

endmodule

@@ rtl/ssw_update.sv @@
// Elapsed-time computation and min/max update for one request.
module ssw_update (
  input  logic [1:0]               func,
  input  logic                     bad_slot,
  input  logic [31:0]              timestamp,
  input  ssw_pkg::slot_rec_t       rec,
  output ssw_pkg::rec_wr_t         wr,
  output ssw_pkg::upd_result_t     res
);
  import ssw_pkg::*;

  logic [STAMP_W-1:0] elapsed;
  logic [STAMP_W-1:0] new_max;
  logic [STAMP_W-1:0] new_min;

  assign elapsed = timestamp - rec.begin_stamp;
  assign new_max = (elapsed > rec.max_seen) ? elapsed : rec.max_seen;
  assign new_min = (elapsed < rec.min_seen) ? elapsed : rec.min_seen;

  always_comb begin
    wr.en  = 1'b0;
    wr.rec = rec;
    res.status      = ST_OK;
    res.elapsed     = '0;
    res.max_elapsed = '0;
    res.min_elapsed = '0;
    if (bad_slot) begin
      res.status = ST_BAD_SLOT;
    end else begin
      case (func)
        ACT_BEGIN: begin
          wr.en              = 1'b1;
          wr.rec.begin_stamp = timestamp;
          res.max_elapsed    = rec.max_seen;
          res.min_elapsed    = rec.min_seen;
        end
        ACT_END: begin
          wr.en           = 1'b1;
          wr.rec.max_seen = new_max;
          wr.rec.min_seen = new_min;
          res.elapsed     = elapsed;
          res.max_elapsed = new_max;
          res.min_elapsed = new_min;
        end
        default: begin
          res.status = ST_BAD_ACTION;
        end
      endcase
    end
  end

endmodule

@@ rtl/slot_stopwatch_min_max.sv @@
// Top level of the slot stopwatch bank with per-slot min/max tracking.
//
// Requests arrive on the s_ stream: tuser carries the action (begin, end),
// tdata the slot number and the current 32-bit cycle count. Every request
// gives exactly one result on the m_ stream: tuser carries the status,
// tdata the elapsed count and the slot's maximum and minimum.
// For each request, the accept edge reads the slot record from the
// registered-read record memory, and the finish edge, once the output
// register is free, writes the updated record back and loads the output
// register. The input accepts a new request again once the previous one
// has left the update stage, so no two accesses to a slot record ever
// overlap.
// While the receiver stalls, a finished result waits in the output
// register; one more request may be accepted and then waits, with its
// record read, until the output register frees.
// Reset clears the valid bits of all slots, so every slot reads as begin
// stamp zero, maximum zero and minimum 1000000000; no clearing pass runs.
module slot_stopwatch_min_max #(
  parameter int unsigned SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // slot[4:0], timestamp[36:5], zero pad
  input  logic [1:0]   s_tuser,   // func[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // elapsed[31:0], max_elapsed[63:32], min_elapsed[95:64]
  output logic [1:0]   m_tuser    // status[1:0]
);
  import ssw_pkg::*;

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic        busy;
  logic [1:0]  func_q;
  logic        bad_slot_q;
  logic [31:0] stamp_q;
  logic [AW-1:0] addr_q;

  logic        accept;
  logic        finish;
  logic [4:0]  in_slot;
  logic [31:0] in_stamp;
  logic        in_bad_slot;

  slot_rec_t   rd_rec;
  rec_wr_t     upd_wr;
  rec_wr_t     mem_wr;
  upd_result_t res;

  assign in_slot     = s_tdata[4:0];
  assign in_stamp    = s_tdata[36:5];
  assign in_bad_slot = {1'b0, in_slot} >= 6'(SLOTS);

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign finish   = busy && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q     <= s_tuser;
      bad_slot_q <= in_bad_slot;
      stamp_q    <= in_stamp;
      addr_q     <= in_slot[AW-1:0];
    end
    if (finish) begin
      m_tuser <= res.status;
      m_tdata <= {res.min_elapsed, res.max_elapsed, res.elapsed};
    end
  end

  assign mem_wr.en  = upd_wr.en && finish;
  assign mem_wr.rec = upd_wr.rec;

  ssw_slot_mem #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_slot[AW-1:0]),
    .rd_rec  (rd_rec),
    .wr_addr (addr_q),
    .wr      (mem_wr)
  );

  ssw_update u_update (
    .func      (func_q),
    .bad_slot  (bad_slot_q),
    .timestamp (stamp_q),
    .rec       (rd_rec),
    .wr        (upd_wr),
    .res       (res)
  );

endmodule

@@ dv/slot_stopwatch_min_max_tb.sv @@
// Self-checking testbench for the slot stopwatch bank with min/max tracking.
module slot_stopwatch_min_max_tb;
  import ssw_pkg::*;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned RANDOM_ITEMS = 1930;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam logic [1:0] ACT_SPARE_A = 2'd2;
  localparam logic [1:0] ACT_SPARE_B = 2'd3;

  class slot_timing_board;
    int unsigned slot_count;
    logic [31:0] start_mark [32];
    logic [31:0] peak_span [32];
    logic [31:0] floor_span [32];
    upd_result_t pending_results [$];
    int unsigned mismatches;
    int unsigned n_begin, n_end, n_bad_slot, n_bad_action, n_checked;

    function new(int unsigned count);
      slot_count = count;
      for (int i = 0; i < 32; i++) begin
        start_mark[i] = '0;
        peak_span[i] = '0;
        floor_span[i] = MIN_RESET_VALUE;
      end
      mismatches = 0;
      n_begin = 0;
      n_end = 0;
      n_bad_slot = 0;
      n_bad_action = 0;
      n_checked = 0;
    endfunction

    // Works out the result of one accepted request and queues it.
    function void note_request(logic [1:0] func, logic [4:0] slot,
                               logic [31:0] stamp);
      upd_result_t want;
      logic [31:0] span;
      want = '0;
      want.status = ST_OK;
      if (slot >= slot_count) begin
        // The slot bound wins over the action check.
        want.status = ST_BAD_SLOT;
        n_bad_slot++;
      end else if (func == ACT_BEGIN) begin
        start_mark[slot] = stamp;
        want.max_elapsed = peak_span[slot];
        want.min_elapsed = floor_span[slot];
        n_begin++;
      end else if (func == ACT_END) begin
        span = stamp - start_mark[slot];
        if (span > peak_span[slot]) peak_span[slot] = span;
        if (span < floor_span[slot]) floor_span[slot] = span;
        want.elapsed = span;
        want.max_elapsed = peak_span[slot];
        want.min_elapsed = floor_span[slot];
        n_end++;
      end else begin
        want.status = ST_BAD_ACTION;
        n_bad_action++;
      end
      pending_results.push_back(want);
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch on result %0d, %s: expected %h, got %h",
                 n_checked, what, want, got);
    endfunction

    function void check_result(logic [1:0] status, logic [95:0] data);
      upd_result_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result", '0, data[31:0]);
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status) report("status", 32'(want.status), 32'(status));
      if (data[31:0] !== want.elapsed) report("elapsed", want.elapsed, data[31:0]);
      if (data[63:32] !== want.max_elapsed)
        report("max_elapsed", want.max_elapsed, data[63:32]);
      if (data[95:64] !== want.min_elapsed)
        report("min_elapsed", want.min_elapsed, data[95:64]);
      n_checked++;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [39:0] s_tdata;
  logic [1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [95:0] m_tdata;
  logic [1:0] m_tuser;

  slot_timing_board board;
  bit sender_calm;

  slot_stopwatch_min_max #(
    .SLOTS(NUM_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Entered and left at a falling edge; the item is noted at its accept edge.
  task automatic send_request(input logic [1:0] func, input logic [4:0] slot,
                              input logic [31:0] stamp);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, stamp, slot};
    s_tuser <= func;
    do @(posedge clk); while (!s_tready);
    board.note_request(func, slot, stamp);
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] clock_now;
    int unsigned pick;
    int unsigned failures;
    board = new(NUM_SLOTS);
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    sender_calm = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // End without a begin uses the reset stamp of zero.
    send_request(ACT_END, 5'd0, 32'd5);
    send_request(ACT_BEGIN, 5'd0, 32'd100);
    send_request(ACT_END, 5'd0, 32'd103);
    // Counter wrap between begin and end.
    send_request(ACT_BEGIN, 5'd3, 32'hFFFF_FFF0);
    send_request(ACT_END, 5'd3, 32'h0000_0010);
    // Largest interval: maximum rises, minimum keeps its reset value.
    send_request(ACT_BEGIN, 5'd15, 32'd0);
    send_request(ACT_END, 5'd15, 32'hFFFF_FFFF);
    send_request(ACT_END, 5'd15, 32'd0);
    send_request(ACT_BEGIN, 5'd15, 32'hFFFF_FFFF);
    // Intervals around the minimum's reset value.
    send_request(ACT_BEGIN, 5'd7, 32'd1000);
    send_request(ACT_END, 5'd7, 32'd1000000999);
    send_request(ACT_END, 5'd7, 32'd1000001000);
    send_request(ACT_END, 5'd7, 32'd1000001001);
    send_request(ACT_END, 5'd7, 32'd1000000998);
    // Slots out of range, with every action.
    send_request(ACT_BEGIN, 5'd16, 32'd1);
    send_request(ACT_END, 5'd20, 32'hA5A5_A5A5);
    send_request(ACT_SPARE_A, 5'd31, 32'hFFFF_FFFF);
    send_request(ACT_SPARE_B, 5'd17, 32'd0);
    // Unknown actions on valid slots leave the slot alone.
    send_request(ACT_SPARE_A, 5'd0, 32'h5A5A_5A5A);
    send_request(ACT_SPARE_B, 5'd15, 32'hFFFF_FFFF);
    send_request(ACT_BEGIN, 5'd0, 32'd7);

    clock_now = $urandom;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) sender_calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40)
        send_request(ACT_BEGIN, 5'($urandom_range(0, NUM_SLOTS - 1)), clock_now);
      else if (pick < 80)
        send_request(ACT_END, 5'($urandom_range(0, NUM_SLOTS - 1)), clock_now);
      else if (pick < 88)
        send_request(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)), $urandom);
      else if (pick < 94)
        send_request(2'($urandom_range(0, 3)), 5'($urandom_range(NUM_SLOTS, 31)), $urandom);
      else
        send_request(2'($urandom_range(2, 3)), 5'($urandom_range(0, NUM_SLOTS - 1)), $urandom);

      // Mostly short steps, with rare jumps, near-wrap values and long gaps.
      pick = $urandom_range(0, 199);
      if (pick < 4) clock_now = $urandom;
      else if (pick < 6) clock_now = 32'hFFFF_FF00 + 32'($urandom_range(0, 255));
      else if (pick < 9) clock_now = clock_now + 32'd999999900 + 32'($urandom_range(0, 200));
      else clock_now = clock_now + 32'($urandom_range(0, 300));
    end
    s_tvalid <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    failures = board.mismatches + board.pending_results.size();
    $display("Sent %0d requests: %0d begin, %0d end, %0d bad slot, %0d bad action.",
             board.n_begin + board.n_end + board.n_bad_slot + board.n_bad_action,
             board.n_begin, board.n_end, board.n_bad_slot, board.n_bad_action);
    $display("Compared %0d results under random gaps and one long output stall; %0d failures.",
             board.n_checked, failures);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned gap;
    int unsigned taken;
    bit calm;
    taken = 0;
    calm = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      // One long stall so that the block fills up and holds off its input.
      if (taken == 400) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = calm ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      board.check_result(m_tuser, m_tdata);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : watchdog
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

@@ slot_stopwatch_min_max.f @@
rtl/ssw_pkg.sv
rtl/ssw_slot_mem.sv
rtl/ssw_update.sv
rtl/slot_stopwatch_min_max.sv
dv/slot_stopwatch_min_max_tb.sv
